// File: rtl/link_recovery_escalation_watchdog_unit_defines.svh
// Assertion macros shared by the link recovery watchdog RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef LINK_RECOVERY_ESCALATION_WATCHDOG_UNIT_DEFINES_SVH
`define LINK_RECOVERY_ESCALATION_WATCHDOG_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LREW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LREW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lrew_pkg.sv
// Types, codes and reset constants for the link recovery watchdog.
// No dependencies; used by lrew_if, lrew_policy and the watchdog unit.
package lrew_pkg;

  localparam int TIME_W   = 32;   // width of internal time arithmetic
  localparam int IN_TIME_W = 32;  // width of now_ms on the poll channel
  localparam int CFG_W    = 32;   // widest configuration register
  localparam int CNT_W    = 4;
  localparam int IDX_W    = 3;
  localparam int CMP_W    = (TIME_W > CFG_W) ? TIME_W : CFG_W;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_RECONNECT = 2'd1,
    ACT_REINIT    = 2'd2,
    ACT_RESTART   = 2'd3
  } action_t;

  typedef enum logic [IDX_W-1:0] {
    REG_RECONNECT_DELAY    = 3'd0,
    REG_RECONNECT_INTERVAL = 3'd1,
    REG_REINIT_DELAY       = 3'd2,
    REG_REINIT_INTERVAL    = 3'd3,
    REG_RESTART_DELAY      = 3'd4,
    REG_MAX_RECONNECTS     = 3'd5
  } reg_index_t;

  localparam logic [CFG_W-1:0] RST_RECONNECT_DELAY    = 32'd5000;
  localparam logic [CFG_W-1:0] RST_RECONNECT_INTERVAL = 32'd10000;
  localparam logic [CFG_W-1:0] RST_REINIT_DELAY       = 32'd45000;
  localparam logic [CFG_W-1:0] RST_REINIT_INTERVAL    = 32'd60000;
  localparam logic [CFG_W-1:0] RST_RESTART_DELAY      = 32'd300000;
  localparam logic [CNT_W-1:0] RST_MAX_RECONNECTS     = 4'd3;

  typedef struct packed {
    logic [CFG_W-1:0] reconnect_delay;
    logic [CFG_W-1:0] reconnect_interval;
    logic [CFG_W-1:0] reinit_delay;
    logic [CFG_W-1:0] reinit_interval;
    logic [CFG_W-1:0] restart_delay;
    logic [CNT_W-1:0] max_reconnects;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] outage_start;
    logic [TIME_W-1:0] last_action_time;
    logic [CNT_W-1:0]  reconnect_count;
    logic              reinit_done;
  } track_t;

endpackage

// File: rtl/lrew_if.sv
// Valid/ready channel interfaces for the poll input and the action result.
// Depends on lrew_pkg for field widths.
interface lrew_poll_if;
  logic                             valid;
  logic                             ready;
  logic [lrew_pkg::IN_TIME_W-1:0]   now_ms;
  logic                             link_up;

  modport source (output valid, output now_ms, output link_up, input ready);
  modport sink   (input valid, input now_ms, input link_up, output ready);
endinterface

interface lrew_act_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [lrew_pkg::CNT_W-1:0]   attempt_count;
  logic                         offline;

  modport source (output valid, output action, output attempt_count, output offline,
                  input ready);
  modport sink   (input valid, input action, input attempt_count, input offline,
                  output ready);
endinterface

// File: rtl/lrew_policy.sv
// Escalation policy: one poll against the tracking state gives the action
// and the next tracking state. Pure logic; depends on lrew_pkg.
module lrew_policy (
  input  lrew_pkg::cfg_t                  cfg,
  input  lrew_pkg::track_t                track,
  input  logic [lrew_pkg::IN_TIME_W-1:0]  now_ms,
  input  logic                            link_up,
  output lrew_pkg::track_t                track_next,
  output lrew_pkg::action_t               action
);

  logic [lrew_pkg::TIME_W-1:0] now;
  logic [lrew_pkg::TIME_W-1:0] offline_time;
  logic [lrew_pkg::TIME_W-1:0] since_action;
  logic                        restart_due;
  logic                        reinit_due;
  logic                        reconnect_due;

  assign now          = lrew_pkg::TIME_W'(now_ms);
  assign offline_time = now - track.outage_start;
  assign since_action = now - track.last_action_time;

  assign restart_due = lrew_pkg::CMP_W'(offline_time) >= lrew_pkg::CMP_W'(cfg.restart_delay);
  assign reinit_due  = (lrew_pkg::CMP_W'(offline_time) >= lrew_pkg::CMP_W'(cfg.reinit_delay))
                       && (!track.reinit_done ||
                           lrew_pkg::CMP_W'(since_action) >=
                           lrew_pkg::CMP_W'(cfg.reinit_interval));
  assign reconnect_due =
      (lrew_pkg::CMP_W'(offline_time) >= lrew_pkg::CMP_W'(cfg.reconnect_delay))
      && (track.reconnect_count < cfg.max_reconnects)
      && (lrew_pkg::CMP_W'(since_action) >= lrew_pkg::CMP_W'(cfg.reconnect_interval));

  always_comb begin
    track_next = track;
    action     = lrew_pkg::ACT_NONE;
    if (link_up) begin
      track_next = '0;
    end else if (track.outage_start == '0) begin
      // zero marks "no outage", so an outage opening at time zero is kept as 1
      track_next.outage_start     = (now == '0) ? lrew_pkg::TIME_W'(1) : now;
      track_next.last_action_time = now;
      track_next.reconnect_count  = '0;
      track_next.reinit_done      = 1'b0;
    end else if (restart_due) begin
      action     = lrew_pkg::ACT_RESTART;
      track_next = '0;
    end else if (reinit_due) begin
      action                      = lrew_pkg::ACT_REINIT;
      track_next.last_action_time = now;
      track_next.reconnect_count  = '0;
      track_next.reinit_done      = 1'b1;
    end else if (reconnect_due) begin
      action                      = lrew_pkg::ACT_RECONNECT;
      track_next.reconnect_count  = track.reconnect_count + lrew_pkg::CNT_W'(1);
      track_next.last_action_time = now;
    end
  end

endmodule

// File: rtl/link_recovery_escalation_watchdog_unit.sv
// Link recovery watchdog: takes one poll (time, link status) per cycle and
// returns one recovery action per poll (none, reconnect, reinit, restart).
// Throughput is one poll per clock while the result side keeps up; each poll passes
// through the input register and then the result register, and the tracking state
// is updated as the poll moves from the first to the second. Both
// registers stall only when the result side holds ready low. Configuration
// writes take effect on the next cycle and should be made while idle.
// Depends on lrew_pkg, lrew_if, lrew_policy and the assertion header.
`include "link_recovery_escalation_watchdog_unit_defines.svh"

module link_recovery_escalation_watchdog_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lrew_pkg::IDX_W-1:0]    cfg_index,
  input  logic [lrew_pkg::CFG_W-1:0]    cfg_wdata,
  lrew_poll_if.sink                     poll,
  lrew_act_if.source                    result
);

  lrew_pkg::cfg_t    cfg;
  lrew_pkg::track_t  track;
  lrew_pkg::track_t  track_next;
  lrew_pkg::action_t action_next;

  logic                             s1_valid;
  logic [lrew_pkg::IN_TIME_W-1:0]   s1_now;
  logic                             s1_up;
  logic                             out_valid;
  logic                             out_take;
  logic                             s1_fire;
  logic [1:0]                       out_action;
  logic [lrew_pkg::CNT_W-1:0]       out_attempt;
  logic                             out_offline;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reconnect_delay    <= lrew_pkg::RST_RECONNECT_DELAY;
      cfg.reconnect_interval <= lrew_pkg::RST_RECONNECT_INTERVAL;
      cfg.reinit_delay       <= lrew_pkg::RST_REINIT_DELAY;
      cfg.reinit_interval    <= lrew_pkg::RST_REINIT_INTERVAL;
      cfg.restart_delay      <= lrew_pkg::RST_RESTART_DELAY;
      cfg.max_reconnects     <= lrew_pkg::RST_MAX_RECONNECTS;
    end else if (cfg_we) begin
      case (cfg_index)
        lrew_pkg::REG_RECONNECT_DELAY:    cfg.reconnect_delay    <= cfg_wdata;
        lrew_pkg::REG_RECONNECT_INTERVAL: cfg.reconnect_interval <= cfg_wdata;
        lrew_pkg::REG_REINIT_DELAY:       cfg.reinit_delay       <= cfg_wdata;
        lrew_pkg::REG_REINIT_INTERVAL:    cfg.reinit_interval    <= cfg_wdata;
        lrew_pkg::REG_RESTART_DELAY:      cfg.restart_delay      <= cfg_wdata;
        lrew_pkg::REG_MAX_RECONNECTS:
          cfg.max_reconnects <= cfg_wdata[lrew_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_take   = !out_valid || result.ready;
  assign s1_fire    = s1_valid && out_take;
  assign poll.ready = !s1_valid || out_take;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_now <= poll.now_ms;
      s1_up  <= poll.link_up;
    end
  end

  lrew_policy u_policy (
    .cfg        (cfg),
    .track      (track),
    .now_ms     (s1_now),
    .link_up    (s1_up),
    .track_next (track_next),
    .action     (action_next)
  );

  // tracking state advances only when a poll moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      track <= '0;
    end else if (s1_fire) begin
      track <= track_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_action  <= action_next;
      out_attempt <= track_next.reconnect_count;
      out_offline <= (track_next.outage_start != '0);
    end
  end

  assign result.valid         = out_valid;
  assign result.action        = out_action;
  assign result.attempt_count = out_attempt;
  assign result.offline       = out_offline;

  `LREW_ASSERT_NOW(a_restart_clears, out_valid && out_action == lrew_pkg::ACT_RESTART, out_attempt == '0 && !out_offline, "restart result must report a cleared state")
  `LREW_ASSERT_NOW(a_reconnect_counts, out_valid && out_action == lrew_pkg::ACT_RECONNECT, out_attempt != '0, "reconnect result must carry a nonzero attempt count")
  `LREW_ASSERT_NOW(a_idle_track_clear, track.outage_start == '0, track.reconnect_count == '0 && !track.reinit_done, "tracking state set without an outage")
  `LREW_ASSERT_NEXT(a_link_up_online, s1_fire && s1_up, out_valid && !out_offline && out_action == lrew_pkg::ACT_NONE, "link-up poll must give an online, no-action result")

endmodule

// File: test/link_recovery_escalation_watchdog_unit_tb.sv
// Testbench for link_recovery_escalation_watchdog_unit: drives service polls,
// predicts each recovery action in-line and checks every result in order.
// Depends on lrew_pkg, lrew_if and the watchdog RTL.
`timescale 1ns / 1ps

module link_recovery_escalation_watchdog_unit_tb;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    lrew_pkg::action_t          action;
    logic [lrew_pkg::CNT_W-1:0] attempts;
    logic                       offline;
  } verdict_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [lrew_pkg::IDX_W-1:0]  cfg_index;
  logic [lrew_pkg::CFG_W-1:0]  cfg_wdata;

  lrew_poll_if poll_ch ();
  lrew_act_if  act_ch ();

  link_recovery_escalation_watchdog_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .poll      (poll_ch),
    .result    (act_ch)
  );

  // Mirror of the block's registers and outage tracking.
  lrew_pkg::cfg_t              policy;
  logic [lrew_pkg::TIME_W-1:0] down_since;
  logic [lrew_pkg::TIME_W-1:0] last_action;
  logic [lrew_pkg::CNT_W-1:0]  tries;
  logic                        reinit_seen;

  verdict_t due_actions[$];
  int       mismatches;
  int       cycles;
  bit       tx_gaps;
  bit       rx_stalls;
  int       rx_hold;

  function automatic void clear_outage();
    down_since  = '0;
    last_action = '0;
    tries       = '0;
    reinit_seen = 1'b0;
  endfunction

  function automatic verdict_t advance_watchdog(input logic [lrew_pkg::TIME_W-1:0] now,
                                                input logic up);
    verdict_t                    v;
    logic [lrew_pkg::TIME_W-1:0] down_for;
    logic [lrew_pkg::TIME_W-1:0] idle_for;
    v.action = lrew_pkg::ACT_NONE;
    if (up) begin
      clear_outage();
    end else if (down_since == '0) begin
      // zero means no outage, so an outage starting at zero is held as one
      down_since  = (now == '0) ? lrew_pkg::TIME_W'(1) : now;
      last_action = now;
      tries       = '0;
      reinit_seen = 1'b0;
    end else begin
      down_for = now - down_since;
      idle_for = now - last_action;
      if (down_for >= policy.restart_delay) begin
        v.action = lrew_pkg::ACT_RESTART;
        clear_outage();
      end else if (down_for >= policy.reinit_delay &&
                   (!reinit_seen || idle_for >= policy.reinit_interval)) begin
        v.action    = lrew_pkg::ACT_REINIT;
        last_action = now;
        tries       = '0;
        reinit_seen = 1'b1;
      end else if (down_for >= policy.reconnect_delay && tries < policy.max_reconnects &&
                   idle_for >= policy.reconnect_interval) begin
        v.action    = lrew_pkg::ACT_RECONNECT;
        tries       = tries + 1'b1;
        last_action = now;
      end
    end
    v.attempts = tries;
    v.offline  = (down_since != '0);
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("link_recovery_escalation_watchdog_unit_tb: errors");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off when a test asks for one.
  initial begin : result_sink
    int stall;
    stall = 0;
    act_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        act_ch.ready <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        act_ch.ready <= 1'b0;
        stall--;
      end else begin
        act_ch.ready <= 1'b1;
        if (rx_stalls) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && act_ch.valid === 1'b1 && act_ch.ready === 1'b1) begin
      if (due_actions.size() == 0) begin
        report($sformatf("t=%0t unexpected result: action=%0d attempts=%0d offline=%0b",
                         $realtime, act_ch.action, act_ch.attempt_count, act_ch.offline));
      end else begin
        want = due_actions.pop_front();
        if (act_ch.action !== want.action || act_ch.attempt_count !== want.attempts ||
            act_ch.offline !== want.offline) begin
          report($sformatf({"t=%0t mismatch: action exp %0d got %0d, attempts exp %0d ",
                            "got %0d, offline exp %0b got %0b"}, $realtime, want.action,
                           act_ch.action, want.attempts, act_ch.attempt_count,
                           want.offline, act_ch.offline));
        end
      end
    end
  end

  task automatic send_poll(input logic [lrew_pkg::TIME_W-1:0] now, input logic up);
    int gap;
    poll_ch.valid   <= 1'b1;
    poll_ch.now_ms  <= now;
    poll_ch.link_up <= up;
    do @(posedge clk); while (poll_ch.ready !== 1'b1);
    due_actions.push_back(advance_watchdog(now, up));
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and let every transfer in flight drain out.
  task automatic wait_idle();
    poll_ch.valid <= 1'b0;
    while (due_actions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(input lrew_pkg::reg_index_t idx,
                           input logic [lrew_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      lrew_pkg::REG_RECONNECT_DELAY:    policy.reconnect_delay    = val;
      lrew_pkg::REG_RECONNECT_INTERVAL: policy.reconnect_interval = val;
      lrew_pkg::REG_REINIT_DELAY:       policy.reinit_delay       = val;
      lrew_pkg::REG_REINIT_INTERVAL:    policy.reinit_interval    = val;
      lrew_pkg::REG_RESTART_DELAY:      policy.restart_delay      = val;
      lrew_pkg::REG_MAX_RECONNECTS:     policy.max_reconnects     = val[lrew_pkg::CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_policy(input logic [lrew_pkg::CFG_W-1:0] rc_delay,
                              input logic [lrew_pkg::CFG_W-1:0] rc_gap,
                              input logic [lrew_pkg::CFG_W-1:0] ri_delay,
                              input logic [lrew_pkg::CFG_W-1:0] ri_gap,
                              input logic [lrew_pkg::CFG_W-1:0] rs_delay,
                              input logic [lrew_pkg::CFG_W-1:0] limit);
    wait_idle();
    write_reg(lrew_pkg::REG_RECONNECT_DELAY, rc_delay);
    write_reg(lrew_pkg::REG_RECONNECT_INTERVAL, rc_gap);
    write_reg(lrew_pkg::REG_REINIT_DELAY, ri_delay);
    write_reg(lrew_pkg::REG_REINIT_INTERVAL, ri_gap);
    write_reg(lrew_pkg::REG_RESTART_DELAY, rs_delay);
    write_reg(lrew_pkg::REG_MAX_RECONNECTS, limit);
    cfg_we <= 1'b0;
  endtask

  // Full escalation under reset values, starting an outage at time zero.
  task automatic test_default_escalation();
    send_poll(32'd0, 1'b0);
    send_poll(32'd5000, 1'b0);
    send_poll(32'd10000, 1'b0);
    send_poll(32'd20000, 1'b0);
    send_poll(32'd30000, 1'b0);
    send_poll(32'd40000, 1'b0);
    send_poll(32'd45001, 1'b0);
    send_poll(32'd300001, 1'b0);
    send_poll(32'd300002, 1'b1);
  endtask

  task automatic test_time_wrap();
    send_poll(32'hFFFF_FFFF, 1'b0);
    send_poll(32'h0000_1000, 1'b0);
    send_poll(32'h0000_3000, 1'b0);
    send_poll(32'hFFFF_FFFF, 1'b1);
  endtask

  // All-zero registers restart on the second poll; all-ones never act.
  task automatic test_register_extremes();
    write_policy('0, '0, '0, '0, '0, '0);
    send_poll(32'd123, 1'b0);
    send_poll(32'd123, 1'b0);
    write_policy('1, '1, '1, '1, '1, '1);
    send_poll(32'd0, 1'b0);
    send_poll(32'hFFFF_FFFE, 1'b0);
    send_poll(32'h7FFF_FFFF, 1'b1);
  endtask

  task automatic test_random_outages(input int polls, input int unsigned step_max);
    int                          done;
    int                          len;
    logic [lrew_pkg::TIME_W-1:0] t;
    done = 0;
    while (done < polls) begin
      if ($urandom_range(0, 99) < 15) begin
        send_poll($urandom, 1'($urandom_range(0, 1)));
        done++;
      end else begin
        t   = $urandom;
        len = $urandom_range(4, 30);
        if ($urandom_range(0, 1) == 1) begin
          send_poll(t, 1'b1);
          done++;
        end
        for (int i = 0; i < len; i++) begin
          // a few polls step back in time or bounce the link
          if ($urandom_range(0, 99) < 5) t = t - $urandom_range(0, step_max);
          else t = t + $urandom_range(0, step_max);
          send_poll(t, 1'($urandom_range(0, 99) < 3));
          done++;
        end
      end
    end
  endtask

  // Hold the result side off long enough for the block to back up its input.
  task automatic test_backpressure();
    logic [lrew_pkg::TIME_W-1:0] t;
    wait_idle();
    tx_gaps = 1'b0;
    t = $urandom;
    rx_hold = 200;
    for (int i = 0; i < 30; i++) begin
      t = t + $urandom_range(0, 80);
      send_poll(t, 1'($urandom_range(0, 99) < 5));
    end
    wait_idle();
  endtask

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= lrew_pkg::REG_RECONNECT_DELAY;
    cfg_wdata         <= '0;
    poll_ch.valid     <= 1'b0;
    poll_ch.now_ms    <= '0;
    poll_ch.link_up   <= 1'b0;
    mismatches = 0;
    cycles     = 0;
    rx_hold    = 0;
    tx_gaps    = 1'b0;
    rx_stalls  = 1'b0;
    policy.reconnect_delay    = lrew_pkg::RST_RECONNECT_DELAY;
    policy.reconnect_interval = lrew_pkg::RST_RECONNECT_INTERVAL;
    policy.reinit_delay       = lrew_pkg::RST_REINIT_DELAY;
    policy.reinit_interval    = lrew_pkg::RST_REINIT_INTERVAL;
    policy.restart_delay      = lrew_pkg::RST_RESTART_DELAY;
    policy.max_reconnects     = lrew_pkg::RST_MAX_RECONNECTS;
    clear_outage();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_escalation();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    test_time_wrap();
    test_register_extremes();

    write_policy(lrew_pkg::RST_RECONNECT_DELAY, lrew_pkg::RST_RECONNECT_INTERVAL,
                 lrew_pkg::RST_REINIT_DELAY, lrew_pkg::RST_REINIT_INTERVAL,
                 lrew_pkg::RST_RESTART_DELAY, lrew_pkg::CFG_W'(lrew_pkg::RST_MAX_RECONNECTS));
    test_random_outages(90, 40000);

    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    write_policy($urandom_range(0, 200), $urandom_range(0, 100), $urandom_range(100, 600),
                 $urandom_range(0, 300), $urandom_range(400, 2000), $urandom);
    test_random_outages(90, 120);

    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    // many cheap reconnects so the attempt count climbs to its ceiling
    write_policy($urandom_range(0, 20), 32'd0, $urandom_range(1500, 3000),
                 $urandom_range(0, 300), $urandom_range(3000, 6000), 32'hFFFF_FFFF);
    test_random_outages(90, 60);

    write_policy($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    test_random_outages(60, 32'hFFFF_FFFF);

    write_policy($urandom_range(0, 300), $urandom_range(0, 200), $urandom_range(200, 900),
                 $urandom_range(0, 400), $urandom_range(900, 3000), $urandom_range(0, 15));
    test_random_outages(70, 150);
    test_backpressure();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("link_recovery_escalation_watchdog_unit_tb: clean");
    end else begin
      $display("link_recovery_escalation_watchdog_unit_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lrew_pkg.sv
rtl/lrew_if.sv
rtl/lrew_policy.sv
rtl/link_recovery_escalation_watchdog_unit.sv
test/link_recovery_escalation_watchdog_unit_tb.sv
